@@ sv/orot_pkg.sv @@
// shared constants for the oriented rectangle overlap test
// no dependencies
package orot_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned TRIG_BITS_DEF  = 16;
  localparam int unsigned IN_DEPTH       = 2;
  localparam int unsigned OUT_DEPTH      = 8;
  localparam int unsigned PIPE_STAGES    = 5;

  // corner order LB, RB, RT, LT; a set bit means the +1 side
  localparam logic [3:0] CORNER_SX = 4'b0110;
  localparam logic [3:0] CORNER_SY = 4'b1100;

endpackage

@@ sv/orot_front.sv @@
// front queue: takes rectangle pairs and packs them for the compute pipeline
// depends on orot_pkg
module orot_front import orot_pkg::*; #(
  parameter int unsigned CW = COORD_BITS_DEF,
  parameter int unsigned TW = TRIG_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [CW-1:0]       a_cx_i,
  input  logic [CW-1:0]       a_cy_i,
  input  logic [CW-2:0]       a_w_i,
  input  logic [CW-2:0]       a_h_i,
  input  logic [TW-1:0]       a_c_i,
  input  logic [TW-1:0]       a_s_i,
  input  logic [CW-1:0]       b_cx_i,
  input  logic [CW-1:0]       b_cy_i,
  input  logic [CW-2:0]       b_w_i,
  input  logic [CW-2:0]       b_h_i,
  input  logic [TW-1:0]       b_c_i,
  input  logic [TW-1:0]       b_s_i,
  output logic                v_o,
  input  logic                take_i,
  output logic [2*(4*CW+2*TW-2)-1:0] item_o
);
  localparam int unsigned RW = 4*CW + 2*TW - 2;
  localparam int unsigned PTR_W = $clog2(IN_DEPTH);
  localparam int unsigned CNT_W = $clog2(IN_DEPTH + 1);

  logic [2*RW-1:0] mem_q [IN_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic wr, rd;

  assign full = (cnt_q == CNT_W'(IN_DEPTH));
  assign v_o  = (cnt_q != '0);
  assign wr   = push && !full;
  assign rd   = take_i && v_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr) begin
      wr_d = (wr_q == PTR_W'(IN_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (rd) begin
      rd_d = (rd_q == PTR_W'(IN_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr && rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_q] <= {b_s_i, b_c_i, b_h_i, b_w_i, b_cy_i, b_cx_i,
                      a_s_i, a_c_i, a_h_i, a_w_i, a_cy_i, a_cx_i};
    end
  end

  assign item_o = mem_q[rd_q];

endmodule

@@ sv/orot_pipe.sv @@
// compute pipeline: corners, cross products and the overlap decision
// depends on orot_pkg
module orot_pipe import orot_pkg::*; #(
  parameter int unsigned CW = COORD_BITS_DEF,
  parameter int unsigned TW = TRIG_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       v_i,
  input  logic [2*(4*CW+2*TW-2)-1:0] item_i,
  output logic                       v_o,
  output logic                       hit_o
);
  localparam int unsigned WW  = CW - 1;
  localparam int unsigned RW  = 4*CW + 2*TW - 2;
  localparam int unsigned PRW = CW + TW;
  localparam int unsigned SW  = PRW + 2;
  localparam int unsigned PW  = CW + 3;
  localparam int unsigned DW  = PW + 1;
  localparam int unsigned XW  = 2*DW;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TW - 1);

  logic [PIPE_STAGES-1:0] v_q;

  // stage 1: rotation products
  logic signed [PRW-1:0] wc_d [2], hs_d [2], ws_d [2], hc_d [2];
  logic signed [PRW-1:0] wc_q [2], hs_q [2], ws_q [2], hc_q [2];
  logic signed [CW-1:0]  cx_d [2], cy_d [2], cx_q [2], cy_q [2];

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      cx_d[r] = $signed(item_i[r*RW +: CW]);
      cy_d[r] = $signed(item_i[r*RW + CW +: CW]);
      wc_d[r] = $signed({1'b0, item_i[r*RW + 2*CW +: WW]}) *
                $signed(item_i[r*RW + 2*CW + 2*WW +: TW]);
      hc_d[r] = $signed({1'b0, item_i[r*RW + 2*CW + WW +: WW]}) *
                $signed(item_i[r*RW + 2*CW + 2*WW +: TW]);
      ws_d[r] = $signed({1'b0, item_i[r*RW + 2*CW +: WW]}) *
                $signed(item_i[r*RW + 2*CW + 2*WW + TW +: TW]);
      hs_d[r] = $signed({1'b0, item_i[r*RW + 2*CW + WW +: WW]}) *
                $signed(item_i[r*RW + 2*CW + 2*WW + TW +: TW]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 2; r++) begin
      cx_q[r] <= cx_d[r];
      cy_q[r] <= cy_d[r];
      wc_q[r] <= wc_d[r];
      hs_q[r] <= hs_d[r];
      ws_q[r] <= ws_d[r];
      hc_q[r] <= hc_d[r];
    end
  end

  // stage 2: corners, round half up
  logic signed [PW-1:0] px_d [2][4], py_d [2][4], px_q [2][4], py_q [2][4];

  always_comb begin
    logic signed [SW-1:0] tx, ty, ox, oy;
    for (int r = 0; r < 2; r++) begin
      for (int k = 0; k < 4; k++) begin
        tx = CORNER_SX[k] ? SW'(wc_q[r]) : -SW'(wc_q[r]);
        ty = CORNER_SY[k] ? SW'(hs_q[r]) : -SW'(hs_q[r]);
        ox = tx - ty + HALF;
        tx = CORNER_SX[k] ? SW'(ws_q[r]) : -SW'(ws_q[r]);
        ty = CORNER_SY[k] ? SW'(hc_q[r]) : -SW'(hc_q[r]);
        oy = tx + ty + HALF;
        px_d[r][k] = PW'(cx_q[r]) + PW'($signed(ox[SW-1:TW]));
        py_d[r][k] = PW'(cy_q[r]) + PW'($signed(oy[SW-1:TW]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
  end

  // stage 3: cross product terms
  logic signed [XW-1:0] m1_d [2][4][4], m2_d [2][4][4], m1_q [2][4][4], m2_q [2][4][4];
  logic signed [XW-1:0] e_d [4][4][6], e_q [4][4][6];

  always_comb begin
    logic signed [DW-1:0] ax, ay, bx, by, rx, ry;
    for (int x = 0; x < 2; x++) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 4; k++) begin
          ax = DW'(px_q[1-x][(k+1)%4]) - DW'(px_q[1-x][k]);
          ay = DW'(py_q[1-x][(k+1)%4]) - DW'(py_q[1-x][k]);
          rx = DW'(px_q[x][i]) - DW'(px_q[1-x][k]);
          ry = DW'(py_q[x][i]) - DW'(py_q[1-x][k]);
          m1_d[x][i][k] = ax * ry;
          m2_d[x][i][k] = rx * ay;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        ax = DW'(px_q[0][(i+1)%4]) - DW'(px_q[0][i]);
        ay = DW'(py_q[0][(i+1)%4]) - DW'(py_q[0][i]);
        bx = DW'(px_q[1][(j+1)%4]) - DW'(px_q[1][j]);
        by = DW'(py_q[1][(j+1)%4]) - DW'(py_q[1][j]);
        rx = DW'(px_q[0][i]) - DW'(px_q[1][j]);
        ry = DW'(py_q[0][i]) - DW'(py_q[1][j]);
        e_d[i][j][0] = by * ax;
        e_d[i][j][1] = bx * ay;
        e_d[i][j][2] = bx * ry;
        e_d[i][j][3] = by * rx;
        e_d[i][j][4] = ax * ry;
        e_d[i][j][5] = ay * rx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= m1_d;
    m2_q <= m2_d;
    e_q  <= e_d;
  end

  // stage 4: left-of tests and crossing numerators
  logic ins_d, ins_q;
  logic signed [XW:0] den_d [4][4], na_d [4][4], nb_d [4][4];
  logic signed [XW:0] den_q [4][4], na_q [4][4], nb_q [4][4];

  always_comb begin
    logic signed [XW:0] cr;
    logic all_left;
    ins_d = 1'b0;
    for (int x = 0; x < 2; x++) begin
      for (int i = 0; i < 4; i++) begin
        all_left = 1'b1;
        for (int k = 0; k < 4; k++) begin
          cr = (XW+1)'(m1_q[x][i][k]) - (XW+1)'(m2_q[x][i][k]);
          if (cr[XW]) begin
            all_left = 1'b0;
          end
        end
        ins_d = ins_d | all_left;
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        den_d[i][j] = (XW+1)'(e_q[i][j][0]) - (XW+1)'(e_q[i][j][1]);
        na_d[i][j]  = (XW+1)'(e_q[i][j][2]) - (XW+1)'(e_q[i][j][3]);
        nb_d[i][j]  = (XW+1)'(e_q[i][j][4]) - (XW+1)'(e_q[i][j][5]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q <= ins_d;
    den_q <= den_d;
    na_q  <= na_d;
    nb_q  <= nb_d;
  end

  // stage 5: both line parameters within 0..1
  function automatic logic in_unit(input logic signed [XW:0] n, input logic signed [XW:0] d);
    logic signed [XW+1:0] diff;
    logic res;
    if (!d[XW]) begin
      diff = (XW+2)'(d) - (XW+2)'(n);
      res  = !n[XW] && !diff[XW+1];
    end else begin
      diff = (XW+2)'(n) - (XW+2)'(d);
      res  = (n[XW] || (n == '0)) && !diff[XW+1];
    end
    return res;
  endfunction

  logic hit_d, hit_q;

  always_comb begin
    hit_d = ins_q;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if ((den_q[i][j] != '0) && in_unit(na_q[i][j], den_q[i][j]) &&
            in_unit(nb_q[i][j], den_q[i][j])) begin
          hit_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PIPE_STAGES-2:0], v_i};
    end
  end

  assign v_o   = v_q[PIPE_STAGES-1];
  assign hit_o = hit_q;

endmodule

@@ sv/orot_outq.sv @@
// result queue with credit count covering items still in the pipeline
// depends on orot_pkg
module orot_outq import orot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic issue_i,
  output logic credit_o,
  input  logic wr_i,
  input  logic d_i,
  output logic empty,
  input  logic pop,
  output logic q_o
);
  localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  logic mem_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cred_q;
  logic rd;

  assign empty    = (cnt_q == '0);
  assign rd       = pop && !empty;
  assign credit_o = (cred_q != CNT_W'(OUT_DEPTH));
  assign q_o      = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      cred_q <= '0;
    end else begin
      if (wr_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd) begin
        rd_q <= rd_q + 1'b1;
      end
      if (wr_i && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_i && rd) begin
        cnt_q <= cnt_q - 1'b1;
      end
      // outstanding = in pipeline plus waiting here
      if (issue_i && !rd) begin
        cred_q <= cred_q + 1'b1;
      end else if (!issue_i && rd) begin
        cred_q <= cred_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_q] <= d_i;
    end
  end

endmodule

@@ sv/oriented_rectangle_overlap_test_top.sv @@
// path: input queue, then the 5 pipeline stages, then the result queue that drives overlap_o
// throughput: one rectangle pair per cycle while results are popped
// the 5-stage compute pipeline, fed from a 2-entry input queue, sets that rate
// reset: asynchronous active low, clears queues and pipeline valid bits
// top level: input queue, compute pipeline, result queue; uses orot_pkg
module oriented_rectangle_overlap_test_top import orot_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned TRIG_BITS  = TRIG_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] a_center_x_i,
  input  logic [COORD_BITS-1:0] a_center_y_i,
  input  logic [COORD_BITS-2:0] a_width_i,
  input  logic [COORD_BITS-2:0] a_height_i,
  input  logic [TRIG_BITS-1:0]  a_cos_i,
  input  logic [TRIG_BITS-1:0]  a_sin_i,
  input  logic [COORD_BITS-1:0] b_center_x_i,
  input  logic [COORD_BITS-1:0] b_center_y_i,
  input  logic [COORD_BITS-2:0] b_width_i,
  input  logic [COORD_BITS-2:0] b_height_i,
  input  logic [TRIG_BITS-1:0]  b_cos_i,
  input  logic [TRIG_BITS-1:0]  b_sin_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  overlap_o
);
  localparam int unsigned RW = 4*COORD_BITS + 2*TRIG_BITS - 2;

  logic [2*RW-1:0] item;
  logic front_v, credit, issue, pipe_v, pipe_hit;

  assign issue = front_v && credit;

  orot_front #(.CW(COORD_BITS), .TW(TRIG_BITS)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .a_cx_i(a_center_x_i), .a_cy_i(a_center_y_i), .a_w_i(a_width_i),
    .a_h_i(a_height_i), .a_c_i(a_cos_i), .a_s_i(a_sin_i),
    .b_cx_i(b_center_x_i), .b_cy_i(b_center_y_i), .b_w_i(b_width_i),
    .b_h_i(b_height_i), .b_c_i(b_cos_i), .b_s_i(b_sin_i),
    .v_o(front_v), .take_i(issue), .item_o(item)
  );

  orot_pipe #(.CW(COORD_BITS), .TW(TRIG_BITS)) u_pipe (
    .clk_i, .rst_ni, .v_i(issue), .item_i(item), .v_o(pipe_v), .hit_o(pipe_hit)
  );

  orot_outq u_outq (
    .clk_i, .rst_ni, .issue_i(issue), .credit_o(credit), .wr_i(pipe_v),
    .d_i(pipe_hit), .empty, .pop, .q_o(overlap_o)
  );

`ifndef SYNTHESIS
  a_pipe_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_v |-> $past(issue, PIPE_STAGES))
    else $error("pipeline result without matching issue");
  a_full_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> front_v)
    else $error("input queue full but nothing to issue");
`endif

endmodule

@@ bench/tb_top.sv @@
// testbench for the oriented rectangle overlap test: directed and random pairs
// checked against a local integer predictor; depends on orot_pkg and the top level
`timescale 1ns / 1ps
module tb_top;
  import orot_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int TB = TRIG_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [CB-2:0]        w;
    logic [CB-2:0]        h;
    logic signed [TB-1:0] c;
    logic signed [TB-1:0] s;
  } rect_t;

  logic clk_i, rst_ni, push, full, empty, pop, overlap_o;
  rect_t ra, rb;

  bit   overlap_q[$];
  int   mismatches, checked, sent, hits, cycles;
  bit   quiet, hold_req;

  oriented_rectangle_overlap_test_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .a_center_x_i(ra.cx), .a_center_y_i(ra.cy), .a_width_i(ra.w), .a_height_i(ra.h),
    .a_cos_i(ra.c), .a_sin_i(ra.s),
    .b_center_x_i(rb.cx), .b_center_y_i(rb.cy), .b_width_i(rb.w), .b_height_i(rb.h),
    .b_cos_i(rb.c), .b_sin_i(rb.s),
    .empty(empty), .pop(pop), .overlap_o(overlap_o)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // corners in order LB, RB, RT, LT, as integers (no fraction bits), rounded half up
  function automatic void rect_corners(input rect_t r, output longint qx[4],
                                       output longint qy[4]);
    longint dx, dy, cw, sw;
    cw = longint'(r.c);
    sw = longint'(r.s);
    for (int k = 0; k < 4; k++) begin
      dx = CORNER_SX[k] ? longint'(r.w) : -longint'(r.w);
      dy = CORNER_SY[k] ? longint'(r.h) : -longint'(r.h);
      qx[k] = longint'(r.cx) + ((dx * cw - dy * sw + (64'sd1 <<< (TB - 1))) >>> TB);
      qy[k] = longint'(r.cy) + ((dx * sw + dy * cw + (64'sd1 <<< (TB - 1))) >>> TB);
    end
  endfunction

  function automatic bit point_in_rect(longint px, longint py, longint qx[4], longint qy[4]);
    longint ex, ey;
    for (int k = 0; k < 4; k++) begin
      ex = qx[(k + 1) % 4] - qx[k];
      ey = qy[(k + 1) % 4] - qy[k];
      if (ex * (py - qy[k]) - (px - qx[k]) * ey < 0) return 0;
    end
    return 1;
  endfunction

  function automatic bit param_in_unit(longint num, longint den);
    if (den >= 0) return num >= 0 && den - num >= 0;
    return num <= 0 && num - den >= 0;
  endfunction

  function automatic bit segments_cross(longint sax, longint say, longint eax, longint eay,
                                        longint sbx, longint sby, longint ebx, longint eby);
    longint ax, ay, bx, by, rx, ry, den;
    ax = eax - sax; ay = eay - say;
    bx = ebx - sbx; by = eby - sby;
    rx = sax - sbx; ry = say - sby;
    den = by * ax - bx * ay;
    if (den == 0) return 0;  // parallel edges never cross
    return param_in_unit(bx * ry - by * rx, den) && param_in_unit(ax * ry - ay * rx, den);
  endfunction

  function automatic bit predict_overlap(rect_t a, rect_t b);
    longint ax[4], ay[4], bx[4], by[4];
    rect_corners(a, ax, ay);
    rect_corners(b, bx, by);
    for (int i = 0; i < 4; i++)
      if (point_in_rect(ax[i], ay[i], bx, by) || point_in_rect(bx[i], by[i], ax, ay))
        return 1;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        if (segments_cross(ax[i], ay[i], ax[(i + 1) % 4], ay[(i + 1) % 4],
                           bx[j], by[j], bx[(j + 1) % 4], by[(j + 1) % 4]))
          return 1;
    return 0;
  endfunction

  // push stays high between back-to-back transactions unless a random gap is inserted while not quiet
  task automatic send_pair(rect_t a, rect_t b);
    bit stalled;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    ra <= a;
    rb <= b;
    push <= 1'b1;
    forever begin
      @(negedge clk_i);
      stalled = full;
      @(posedge clk_i);
      if (!stalled) break;
    end
    overlap_q.push_back(predict_overlap(a, b));
    sent++;
  endtask

  function automatic rect_t make_rect(int cx, int cy, int w, int h, int c, int s);
    rect_t r;
    r.cx = CB'(cx); r.cy = CB'(cy); r.w = (CB-1)'(w); r.h = (CB-1)'(h);
    r.c = TB'(c); r.s = TB'(s);
    return r;
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    r.cx = CB'($urandom); r.cy = CB'($urandom);
    r.w = (CB-1)'($urandom); r.h = (CB-1)'($urandom);
    r.c = TB'($urandom); r.s = TB'($urandom);
    return r;
  endfunction

  function automatic rect_t near_rect(int cx, int cy, int span);
    rect_t r;
    real ang;
    ang = $urandom_range(0, 3599) * 3.14159265 / 1800.0;
    r.cx = CB'(cx + $signed($urandom_range(0, 2 * span)) - span);
    r.cy = CB'(cy + $signed($urandom_range(0, 2 * span)) - span);
    r.w = (CB-1)'($urandom_range(0, span));
    r.h = (CB-1)'($urandom_range(0, span));
    r.c = TB'($rtoi($cos(ang) * 32767.0));
    r.s = TB'($rtoi($sin(ang) * 32767.0));
    if ($urandom_range(0, 15) == 0) r.c = TB'(-32768);
    if ($urandom_range(0, 15) == 0) r.s = '0;
    return r;
  endfunction

  task automatic test_directed();
    rect_t u;
    u = make_rect(0, 0, 256, 256, 32767, 0);
    send_pair(u, u);
    send_pair(u, make_rect(100000, 0, 256, 256, 32767, 0));
    send_pair(u, make_rect(256, 0, 256, 256, 32767, 0));           // edges touch
    send_pair(u, make_rect(256, 256, 256, 256, 32767, 0));         // corners touch
    send_pair(u, make_rect(257, 0, 256, 256, 32767, 0));
    send_pair(u, make_rect(0, 0, 4096, 64, 23170, 23170));         // crossing, two corners of u inside
    send_pair(make_rect(0, 0, 2048, 64, 32767, 0), make_rect(0, 0, 64, 2048, 32767, 0));
    send_pair(make_rect(0, 0, 1000, 0, 32767, 0), make_rect(0, 200, 1000, 0, 32767, 0));
    send_pair(make_rect(0, 0, 0, 0, 32767, 0), make_rect(99999, -9999, 300, 300, 0, 32767));
    send_pair(make_rect(5000, 5000, 500, 500, 0, 0), make_rect(-5000, 0, 20, 20, 32767, 0));
    send_pair(make_rect(0, 0, 512, 256, -32768, 0), make_rect(0, 300, 512, 256, 0, -32768));
    send_pair(make_rect(0, 0, 512, 256, 16000, 16000), make_rect(800, 0, 512, 256, 32767, 0));
    send_pair(make_rect(8388607, 8388607, 8388607, 8388607, 32767, 32767),
              make_rect(-8388608, -8388608, 8388607, 8388607, -32768, -32768));
    send_pair(make_rect(-8388608, 8388607, 8388607, 0, -32767, 32767),
              make_rect(8388607, -8388608, 0, 8388607, 32767, -32767));
    send_pair(make_rect(8388607, 0, 1, 1, 32767, 0), make_rect(-8388608, 0, 1, 1, 32767, 0));
  endtask

  task automatic test_near_pairs(int count);
    int bx, by, span;
    for (int n = 0; n < count; n++) begin
      span = ($urandom_range(0, 9) == 0) ? 2000000 : $urandom_range(1, 20000);
      bx = $signed($urandom_range(0, 8000000)) - 4000000;
      by = $signed($urandom_range(0, 8000000)) - 4000000;
      send_pair(near_rect(bx, by, span), near_rect(bx, by, span));
    end
  endtask

  task automatic test_noise(int count);
    for (int n = 0; n < count; n++) send_pair(rand_rect(), rand_rect());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    test_near_pairs(40);
    hold_req = 1'b0;
  endtask

  // result side: random stall bursts, plus a long hold-off when requested
  initial begin
    int hold;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        hold = 0;
        while (hold < 300) begin
          @(posedge clk_i);
          hold++;
        end
        while (hold_req) begin
          pop <= 1'b1;
          @(posedge clk_i);
        end
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // outputs are stable from the falling edge to the next rising edge
  always @(negedge clk_i) begin
    bit exp_ov;
    if (rst_ni && pop && !empty) begin
      checked++;
      if (overlap_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("error: result with no transaction pending");
      end else begin
        exp_ov = overlap_q.pop_front();
        hits += exp_ov;
        if (overlap_o !== exp_ov) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error: result %0d overlap expected %0b actual %0b",
                     checked, exp_ov, overlap_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    ra = '0;
    rb = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_near_pairs(500);
    test_backpressure();
    test_noise(250);
    test_near_pairs(500);
    quiet = 1'b1;
    test_near_pairs(150);
    test_noise(50);
    push <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (overlap_q.size() != 0) mismatches++;
    $display("sent %0d rectangle pairs, checked %0d results, %0d overlapping", sent,
             checked, hits);
    $display("covered touching, crossing, degenerate, extreme and random pairs with stalls");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
